// ===== hdl/sto_pkg.sv =====
// Shared codes and control types for the sparse threshold operator.
package sto_pkg;

    // Penalty mode codes held in the mode register
    localparam logic [1:0] MODE_SOFT   = 2'd0;
    localparam logic [1:0] MODE_SHRINK = 2'd1;
    localparam logic [1:0] MODE_SCAD   = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd1;

    // Per-word control that rides along the divider pipeline
    typedef struct packed {
        logic use_div;  // result comes from the SCAD middle-band quotient
        logic neg;      // sign of the original element
    } t_ctl;

endpackage

// ===== hdl/sparse_threshold_operator_unit.sv =====
// Top level of the sparse threshold operator: config registers, pipeline and output stage.
//
//  channel   direction  handshake                   payload
//  --------  ---------  --------------------------  ------------------------------
//  input     in         i_in_valid / o_in_stall     i_value_in, i_threshold
//  output    out        o_out_valid / i_out_stall   o_value_out
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One word enters per cycle while o_in_stall is low; each word passes the front
//  stages, the divider, which resolves one quotient bit per stage, and the output register.
//  Reset is synchronous and clears the valid bits and loads mode 0 and gamma 3.7.
//  A stall at the output fills empty stages first; o_in_stall rises only once
//  every stage holds a word. Config writes are always taken.
module sparse_threshold_operator_unit
    import sto_pkg::*;
#(
    parameter int  DATA_WIDTH = 32,
    parameter int  FRAC_BITS  = 16,
    localparam int GW         = DATA_WIDTH - 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_value_in,
    input  logic [GW-1:0]                i_threshold,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_value_out
);

    localparam int DW = DATA_WIDTH;
    localparam int NW = GW + DW;
    // Gamma of 3.7 at the configured fraction width
    localparam logic [GW-1:0] GAMMA_RST = GW'((37 * (64'd1 << FRAC_BITS)) / 10);

    logic [1:0]    r_mode;
    logic [GW-1:0] r_gamma;

    logic          f_valid;
    logic          f_stall;
    logic [DW-1:0] f_alt;
    t_ctl          f_ctl;
    logic [NW-1:0] f_num;
    logic [GW-1:0] f_den;

    logic          d_valid;
    logic          d_stall;
    logic [DW-1:0] d_q;
    logic [DW-1:0] d_alt;
    t_ctl          d_ctl;

    logic          out_en;
    logic          r_out_v;
    logic [DW-1:0] r_out;
    logic [DW-1:0] n_out;

    // Config registers: take every write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SOFT;
            r_gamma <= GAMMA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_GAMMA: r_gamma <= i_cfg_data[GW-1:0];
                default:   ;
            endcase
        end
    end

    sto_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_gamma (r_gamma),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_x     (i_value_in),
        .i_l     (i_threshold),
        .o_valid (f_valid),
        .i_stall (f_stall),
        .o_alt   (f_alt),
        .o_ctl   (f_ctl),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    sto_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_alt   (f_alt),
        .i_ctl   (f_ctl),
        .o_valid (d_valid),
        .i_stall (d_stall),
        .o_q     (d_q),
        .o_alt   (d_alt),
        .o_ctl   (d_ctl)
    );

    // Output stage: apply the sign to the quotient or pass the other result.
    // The middle-band quotient never exceeds |x|, so no saturation is needed.
    assign out_en  = !r_out_v || !i_out_stall;
    assign d_stall = !out_en;

    always_comb begin
        if (d_ctl.use_div) begin
            n_out = d_ctl.neg ? (~d_q + 1'b1) : d_q;
        end else begin
            n_out = d_alt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= d_valid;
        end
        if (out_en && d_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_value_out = r_out;

    // Input stall can only come from a stalled, full output stage
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_v && i_out_stall))
        else $error("sto: input stalled without a stalled output");

    // No word leaves right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("sto: output valid right after reset");

endmodule

// ===== hdl/sto_front.sv =====
// Front end: magnitude, gamma products, band classification and non-divide results.
module sto_front
    import sto_pkg::*;
#(
    parameter int  DATA_WIDTH = 32,
    parameter int  FRAC_BITS  = 16,
    localparam int GW         = DATA_WIDTH - 1,
    localparam int NW         = GW + DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_mode,
    input  logic [GW-1:0]                i_gamma,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    input  logic [GW-1:0]                i_l,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [DATA_WIDTH-1:0]        o_alt,
    output t_ctl                         o_ctl,
    output logic [NW-1:0]                o_num,
    output logic [GW-1:0]                o_den
);

    localparam int DW   = DATA_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int WW   = ((DW + FB > 2 * GW) ? DW + FB : 2 * GW) + 1;
    localparam int CMPW = ((GW > FB + 2) ? GW : FB + 2) + 1;

    localparam logic [CMPW-1:0] TWO_C = CMPW'(2) << FB;
    localparam logic [GW-1:0]   ONE_G = GW'(CMPW'(1) << FB);

    // Stage enables: a stage loads when empty or when its word moves on
    logic en1, en2, en3;

    // Stage 1 registers
    logic                 r1_v;
    logic [DW-1:0]        r1_x;
    logic                 r1_neg;
    logic [DW-1:0]        r1_mag;
    logic [GW-1:0]        r1_l;

    // Stage 2 registers
    logic                 r2_v;
    logic [DW-1:0]        r2_x;
    logic                 r2_neg;
    logic [DW-1:0]        r2_mag;
    logic [GW-1:0]        r2_l;
    logic [2*GW-1:0]      r2_gl;
    logic [NW-1:0]        r2_a;
    logic [DW-1:0]        r2_soft;
    logic [DW-1:0]        r2_shrink;

    // Stage 3 registers
    logic                 r3_v;
    logic [DW-1:0]        r3_alt;
    t_ctl                 r3_ctl;
    logic [NW-1:0]        r3_num;
    logic [GW-1:0]        r3_den;

    logic                 n1_neg;
    logic [DW-1:0]        n1_mag;
    logic [GW-1:0]        gm1;
    logic [2*GW-1:0]      n2_gl;
    logic [NW-1:0]        n2_a;
    logic [DW-1:0]        soft_m;
    logic [DW-1:0]        n2_soft;
    logic [DW:0]          shrink_d;
    logic [DW-1:0]        n2_shrink;
    logic [WW-1:0]        magq;
    logic [WW-1:0]        glw;
    logic [WW-1:0]        twol;
    logic                 above_gl;
    logic                 above_2l;
    logic                 gamma_ok;
    logic                 mid_band;
    logic [NW-1:0]        gl_n;
    logic [DW-1:0]        n3_alt;
    t_ctl                 n3_ctl;
    logic [NW-1:0]        n3_num;
    logic [GW-1:0]        n3_den;

    assign en3     = !r3_v || !i_stall;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_stall = !en1;

    // Stage 1: split the element into sign and magnitude
    always_comb begin
        n1_neg = i_x[DW-1];
        n1_mag = n1_neg ? (~i_x + 1'b1) : i_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
        if (en1 && i_valid) begin
            r1_x   <= i_x;
            r1_neg <= n1_neg;
            r1_mag <= n1_mag;
            r1_l   <= i_l;
        end
    end

    // Stage 2: gamma*l and (gamma-1)*|x|, plus soft and shrink results
    always_comb begin
        gm1       = i_gamma - ONE_G;
        n2_gl     = (2 * GW)'(r1_l) * (2 * GW)'(i_gamma);
        n2_a      = NW'(gm1) * NW'(r1_mag);
        soft_m    = (r1_mag > DW'(r1_l)) ? (r1_mag - DW'(r1_l)) : '0;
        n2_soft   = r1_neg ? (~soft_m + 1'b1) : soft_m;
        shrink_d  = {r1_x[DW-1], r1_x} - (DW + 1)'(r1_l);
        n2_shrink = (!shrink_d[DW] && (shrink_d != '0)) ? shrink_d[DW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
        if (en2 && r1_v) begin
            r2_x      <= r1_x;
            r2_neg    <= r1_neg;
            r2_mag    <= r1_mag;
            r2_l      <= r1_l;
            r2_gl     <= n2_gl;
            r2_a      <= n2_a;
            r2_soft   <= n2_soft;
            r2_shrink <= n2_shrink;
        end
    end

    // Stage 3: classify the SCAD band and pick the result that needs no divide
    always_comb begin
        magq     = WW'(r2_mag) << FB;
        glw      = WW'(r2_gl);
        twol     = WW'(r2_l) << (FB + 1);
        above_gl = magq > glw;
        above_2l = magq > twol;
        gamma_ok = CMPW'(i_gamma) > TWO_C;
        mid_band = !above_gl && above_2l && gamma_ok;
        gl_n     = NW'(r2_gl);
        n3_num   = (r2_a > gl_n) ? (r2_a - gl_n) : '0;
        n3_den   = GW'(CMPW'(i_gamma) - TWO_C);
        case (i_mode)
            MODE_SHRINK: n3_alt = r2_shrink;
            MODE_SCAD:   n3_alt = above_gl ? r2_x : r2_soft;
            default:     n3_alt = r2_soft;
        endcase
        n3_ctl.use_div = (i_mode == MODE_SCAD) && mid_band;
        n3_ctl.neg     = r2_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
        if (en3 && r2_v) begin
            r3_alt <= n3_alt;
            r3_ctl <= n3_ctl;
            r3_num <= n3_num;
            r3_den <= n3_den;
        end
    end

    assign o_valid = r3_v;
    assign o_alt   = r3_alt;
    assign o_ctl   = r3_ctl;
    assign o_num   = r3_num;
    assign o_den   = r3_den;

    // A word headed for the divider never carries a zero divisor
    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && r3_ctl.use_div) |-> (r3_den != '0))
        else $error("sto_front: divide word with zero divisor");

    // Upstream stall only when every front stage holds a word
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r1_v && r2_v && r3_v))
        else $error("sto_front: stall raised with a free stage");

endmodule

// ===== hdl/sto_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, control riding alongside.
module sto_divider
    import sto_pkg::*;
#(
    parameter int  DATA_WIDTH = 32,
    localparam int GW         = DATA_WIDTH - 1,
    localparam int NW         = GW + DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [NW-1:0]         i_num,
    input  logic [GW-1:0]         i_den,
    input  logic [DATA_WIDTH-1:0] i_alt,
    input  t_ctl                  i_ctl,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_q,
    output logic [DATA_WIDTH-1:0] o_alt,
    output t_ctl                  o_ctl
);

    localparam int DW = DATA_WIDTH;

    // Stage registers, one entry per quotient bit
    logic          r_v   [DW];
    logic [NW-1:0] r_rem [DW];
    logic [DW-1:0] r_q   [DW];
    logic [GW-1:0] r_den [DW];
    logic [DW-1:0] r_alt [DW];
    t_ctl          r_ctl [DW];
    logic          en    [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        localparam int BI = DW - 1 - k;

        logic          in_v;
        logic [NW-1:0] in_rem;
        logic [DW-1:0] in_q;
        logic [GW-1:0] in_den;
        logic [DW-1:0] in_alt;
        t_ctl          in_ctl;
        logic [NW:0]   trial;
        logic [NW-1:0] n_rem;
        logic [DW-1:0] n_q;

        // Pick up the word from the previous stage or from the ports
        if (k == 0) begin : g_first
            assign in_v   = i_valid;
            assign in_rem = i_num;
            assign in_q   = '0;
            assign in_den = i_den;
            assign in_alt = i_alt;
            assign in_ctl = i_ctl;
        end else begin : g_next
            assign in_v   = r_v[k-1];
            assign in_rem = r_rem[k-1];
            assign in_q   = r_q[k-1];
            assign in_den = r_den[k-1];
            assign in_alt = r_alt[k-1];
            assign in_ctl = r_ctl[k-1];
        end

        // Load when empty or when the held word moves on
        if (k == DW - 1) begin : g_last_en
            assign en[k] = !r_v[k] || !i_stall;
        end else begin : g_mid_en
            assign en[k] = !r_v[k] || en[k+1];
        end

        // Try to subtract the divisor at this bit weight
        always_comb begin
            trial     = {1'b0, in_rem} - ((NW + 1)'(in_den) << BI);
            n_q       = in_q;
            n_q[BI]   = !trial[NW];
            n_rem     = trial[NW] ? in_rem : trial[NW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= in_v;
            end
            if (en[k] && in_v) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_den[k] <= in_den;
                r_alt[k] <= in_alt;
                r_ctl[k] <= in_ctl;
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[DW-1];
    assign o_q     = r_q[DW-1];
    assign o_alt   = r_alt[DW-1];
    assign o_ctl   = r_ctl[DW-1];

    // The quotient fits its bits, so the final remainder is below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[DW-1] && r_ctl[DW-1].use_div) |-> (r_rem[DW-1] < NW'(r_den[DW-1])))
        else $error("sto_divider: quotient overflowed its width");

endmodule
